// File: rtl/mer_pkg.sv
`default_nettype none

package mer_pkg;

    // Width of one box corner coordinate.
    localparam int COORD_BITS = 13;

    // Derived widths of the datapath.
    localparam int RAD_W   = COORD_BITS - 1;        // one radius
    localparam int RSQ_W   = 2 * RAD_W;             // a squared radius
    localparam int OUT_W   = COORD_BITS + 1;        // a result coordinate
    localparam int SLOPE_W = 3 * COORD_BITS + 1;    // slope terms, signed
    localparam int MUL_W   = 2 * COORD_BITS + 2;    // one multiplier operand
    localparam int DEC_W   = 2 * MUL_W;             // decision term, signed

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = ((4 * COORD_BITS + 1 + 7) / 8) * 8;
    localparam int M_DATA_W = ((3 * OUT_W + 1 + 7) / 8) * 8;

    // Command codes carried in the input tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

`default_nettype wire

// File: rtl/midpoint_ellipse_rasterizer.sv
`default_nettype none

// Midpoint ellipse rasterizer. A start word (tuser = 0) carries a bounding box and
// an outline-or-fill flag; it sets up the radii, the centre and the decision terms
// and gives no result. Each step word (tuser = 1) runs one iteration of the
// two-region midpoint method and gives up to four mirrored points (outline) or up
// to two horizontal spans (fill); tlast marks the last word of a step, and the
// finished bit is set on every word of the step that completes the ellipse. A step
// with no ellipse active gives one empty word (tuser = 1). Items are taken one at
// a time: s_tready is high only while the sequencer is idle. All squares and
// products go through a single registered multiplier, one product per cycle. A
// start squares the radii and forms the slope and decision terms, then also runs
// the region change when the box is degenerate enough to enter region two at once.
// A step updates the walk and tests it, runs the region change at the single step
// that changes region, then gives its 1 to 4 result words as the output accepts them.
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Input stream.
    input  wire                 s_tvalid,
    output logic                s_tready,
    // tdata, low bit up: corner_ax, corner_ay, corner_bx, corner_by, solid, zero pad.
    input  wire  [S_DATA_W-1:0] s_tdata,
    // tuser: command.
    input  wire  [0:0]          s_tuser,
    // Output stream.
    output logic                m_tvalid,
    input  wire                 m_tready,
    // tdata, low bit up: span_left, span_right, row, finished, zero pad.
    output logic [M_DATA_W-1:0] m_tdata,
    // tuser: empty_res.
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);

    localparam int C = COORD_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_RX,
        S_SQ_RY,
        S_MUL_SDY,
        S_MUL_RR,
        S_START_FIN,
        S_UPD_A,
        S_UPD_B,
        S_SETTLE,
        S_RC_SQX,
        S_RC_A,
        S_RC_SQY,
        S_RC_B,
        S_RC_FIN,
        S_EMIT
    } t_state;

    t_state r_state;

    // Ellipse state.
    logic signed [C-1:0]       r_cx, r_cy;
    logic [RAD_W-1:0]          r_rx, r_ry;
    logic [RSQ_W-1:0]          r_rx2, r_ry2;
    logic [2*RSQ_W-1:0]        r_rxry;
    logic [C-1:0]              r_wx;
    logic signed [C-1:0]       r_wy;
    logic signed [SLOPE_W-1:0] r_sdx, r_sdy;
    logic signed [DEC_W-1:0]   r_dec;
    logic                      r_reg2, r_active, r_fill;
    logic [DEC_W-1:0]          r_prod;

    // Per-step emit state.
    logic [C-1:0]              r_ex;
    logic signed [C-1:0]       r_ey;
    logic [3:0]                r_mask;
    logic                      r_empty, r_done, r_is_start;

    // Output register.
    logic                      r_m_valid;
    logic [OUT_W-1:0]          r_m_left, r_m_right, r_m_row;
    logic                      r_m_empty, r_m_last, r_m_fin;

    logic                      in_accept;
    logic signed [C-1:0]       in_ax, in_ay, in_bx, in_by;
    logic                      in_solid;

    // Input word unpacking.
    assign in_ax     = s_tdata[C-1:0];
    assign in_ay     = s_tdata[2*C-1:C];
    assign in_bx     = s_tdata[3*C-1:2*C];
    assign in_by     = s_tdata[4*C-1:3*C];
    assign in_solid  = s_tdata[4*C];
    assign s_tready  = (r_state == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Centre and radius of the box; every halving truncates toward zero.
    logic signed [C:0] sum_x, sum_y, rnd_x, rnd_y, half_x, half_y;
    logic signed [C:0] dif_x, dif_y, abs_x, abs_y;

    assign sum_x  = {in_ax[C-1], in_ax} + {in_bx[C-1], in_bx};
    assign sum_y  = {in_ay[C-1], in_ay} + {in_by[C-1], in_by};
    assign rnd_x  = sum_x + {{C{1'b0}}, sum_x[C]};
    assign rnd_y  = sum_y + {{C{1'b0}}, sum_y[C]};
    assign half_x = rnd_x >>> 1;
    assign half_y = rnd_y >>> 1;
    assign dif_x  = {in_ax[C-1], in_ax} - {in_bx[C-1], in_bx};
    assign dif_y  = {in_ay[C-1], in_ay} - {in_by[C-1], in_by};
    assign abs_x  = dif_x[C] ? -dif_x : dif_x;
    assign abs_y  = dif_y[C] ? -dif_y : dif_y;

    // Shared multiplier with operand selection by sequencer state.
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [DEC_W-1:0]   mul_p;
    logic signed [C:0]  ym1, abs_ym1;

    assign ym1     = {r_wy[C-1], r_wy} - 1'b1;
    assign abs_ym1 = ym1[C] ? -ym1 : ym1;

    always_comb begin
        unique case (r_state)
            S_SQ_RX: begin
                mul_a = MUL_W'(r_rx);
                mul_b = MUL_W'(r_rx);
            end
            S_SQ_RY: begin
                mul_a = MUL_W'(r_ry);
                mul_b = MUL_W'(r_ry);
            end
            S_MUL_SDY: begin
                mul_a = MUL_W'(r_rx2);
                mul_b = MUL_W'(r_ry);
            end
            S_MUL_RR: begin
                mul_a = MUL_W'(r_rx2);
                mul_b = MUL_W'(r_ry2);
            end
            S_RC_SQX: begin
                mul_a = MUL_W'({r_wx, 1'b1});
                mul_b = MUL_W'({r_wx, 1'b1});
            end
            S_RC_A: begin
                mul_a = MUL_W'(r_ry2);
                mul_b = r_prod[MUL_W-1:0];
            end
            S_RC_SQY: begin
                mul_a = MUL_W'(abs_ym1[C-1:0]);
                mul_b = MUL_W'(abs_ym1[C-1:0]);
            end
            S_RC_B: begin
                mul_a = MUL_W'(r_rx2);
                mul_b = r_prod[MUL_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Step update terms: slope increments and the decision increment.
    logic                      dec_neg, dec_pos, use_sdx, use_sdy, slope_lt;
    logic [SLOPE_W-1:0]        two_rx2, two_ry2;
    logic [SLOPE_W+1:0]        sdx_e, sdy_e, rsq_e, upd_term;
    logic [DEC_W-1:0]          dec_add;
    logic [RSQ_W+RAD_W-1:0]    p_sdy;

    assign dec_neg  = r_dec[DEC_W-1];
    assign dec_pos  = !dec_neg && (r_dec != '0);
    assign two_rx2  = SLOPE_W'({r_rx2, 1'b0});
    assign two_ry2  = SLOPE_W'({r_ry2, 1'b0});
    assign use_sdx  = !r_reg2 || !dec_pos;
    assign use_sdy  = r_reg2 || !dec_neg;
    assign sdx_e    = use_sdx ? {{2{r_sdx[SLOPE_W-1]}}, r_sdx} : '0;
    assign sdy_e    = use_sdy ? {{2{r_sdy[SLOPE_W-1]}}, r_sdy} : '0;
    assign rsq_e    = (SLOPE_W+2)'(r_reg2 ? r_rx2 : r_ry2);
    assign upd_term = sdx_e - sdy_e + rsq_e;
    assign dec_add  = {{(DEC_W-SLOPE_W-4){upd_term[SLOPE_W+1]}}, upd_term, 2'b00};
    assign slope_lt = (r_sdx < r_sdy);
    assign p_sdy    = r_prod[RSQ_W+RAD_W-1:0];

    // Mirror coordinates of the visited point.
    logic [OUT_W-1:0] px, nx, py, ny;

    assign px = OUT_W'({r_cx[C-1], r_cx[C-1], r_cx} + {2'b00, r_ex});
    assign nx = OUT_W'({r_cx[C-1], r_cx[C-1], r_cx} - {2'b00, r_ex});
    assign py = OUT_W'({r_cy[C-1], r_cy[C-1], r_cy} + {r_ey[C-1], r_ey[C-1], r_ey});
    assign ny = OUT_W'({r_cy[C-1], r_cy[C-1], r_cy} - {r_ey[C-1], r_ey[C-1], r_ey});

    // Pick the next pending result and build its fields.
    logic [1:0]       emit_k;
    logic [3:0]       emit_rest;
    logic [OUT_W-1:0] emit_left, emit_right, emit_row;
    logic             emit_load;

    always_comb begin
        priority if (r_mask[0]) begin
            emit_k = 2'd0;
        end else if (r_mask[1]) begin
            emit_k = 2'd1;
        end else if (r_mask[2]) begin
            emit_k = 2'd2;
        end else begin
            emit_k = 2'd3;
        end
        emit_rest = r_mask & ~(4'b0001 << emit_k);

        priority if (r_empty) begin
            emit_left  = '0;
            emit_right = '0;
            emit_row   = '0;
        end else if (r_fill) begin
            emit_left  = nx;
            emit_right = px;
            emit_row   = (emit_k == 2'd0) ? py : ny;
        end else begin
            emit_left  = (emit_k[0] == 1'b0) ? px : nx;
            emit_right = emit_left;
            emit_row   = (emit_k[1] == 1'b0) ? py : ny;
        end
    end

    assign emit_load = (r_state == S_EMIT) && (!r_m_valid || m_tready);

    // Sequencer, ellipse state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= 1'b0;
            r_reg2    <= 1'b0;
            r_fill    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_prod <= mul_p;

            if (emit_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (s_tuser[0] == CMD_START) begin
                            r_cx       <= half_x[C-1:0];
                            r_cy       <= half_y[C-1:0];
                            r_rx       <= abs_x[C-1:1];
                            r_ry       <= abs_y[C-1:1];
                            r_fill     <= in_solid;
                            r_wx       <= '0;
                            r_wy       <= C'(abs_y[C-1:1]);
                            r_sdx      <= '0;
                            r_reg2     <= 1'b0;
                            r_active   <= 1'b1;
                            r_is_start <= 1'b1;
                            r_state    <= S_SQ_RX;
                        end else if (!r_active) begin
                            r_mask  <= 4'b0001;
                            r_empty <= 1'b1;
                            r_done  <= 1'b0;
                            r_state <= S_EMIT;
                        end else begin
                            r_ex       <= r_wx;
                            r_ey       <= r_wy;
                            r_empty    <= 1'b0;
                            r_is_start <= 1'b0;
                            if (r_fill) begin
                                r_mask <= {2'b00, r_wy != '0, 1'b1};
                            end else begin
                                r_mask <= {r_wy != '0, r_wy != '0, r_wx != '0, 1'b1};
                            end
                            r_state <= S_UPD_A;
                        end
                    end
                end

                S_SQ_RX: begin
                    r_state <= S_SQ_RY;
                end

                S_SQ_RY: begin
                    r_rx2   <= r_prod[RSQ_W-1:0];
                    r_state <= S_MUL_SDY;
                end

                S_MUL_SDY: begin
                    r_ry2   <= r_prod[RSQ_W-1:0];
                    r_state <= S_MUL_RR;
                end

                // Initial slope and decision from rx^2 * ry.
                S_MUL_RR: begin
                    r_sdy   <= SLOPE_W'({p_sdy, 1'b0});
                    r_dec   <= DEC_W'({r_ry2, 2'b00}) - DEC_W'({p_sdy, 2'b00})
                               + DEC_W'(r_rx2);
                    r_state <= S_START_FIN;
                end

                S_START_FIN: begin
                    r_rxry  <= r_prod[2*RSQ_W-1:0];
                    r_state <= S_SETTLE;
                end

                // Walk position and slopes move first.
                S_UPD_A: begin
                    if (!r_reg2) begin
                        r_wx  <= r_wx + 1'b1;
                        r_sdx <= r_sdx + two_ry2;
                        if (!dec_neg) begin
                            r_wy  <= r_wy - 1'b1;
                            r_sdy <= r_sdy - two_rx2;
                        end
                    end else begin
                        r_wy  <= r_wy - 1'b1;
                        r_sdy <= r_sdy - two_rx2;
                        if (!dec_pos) begin
                            r_wx  <= r_wx + 1'b1;
                            r_sdx <= r_sdx + two_ry2;
                        end
                    end
                    r_state <= S_UPD_B;
                end

                // Decision moves with the updated slopes.
                S_UPD_B: begin
                    r_dec   <= r_dec + dec_add;
                    r_state <= S_SETTLE;
                end

                // Region change test, then end test.
                S_SETTLE: begin
                    if (!r_reg2 && !slope_lt) begin
                        r_state <= S_RC_SQX;
                    end else begin
                        if (r_reg2 && r_wy[C-1]) begin
                            r_active <= 1'b0;
                            r_done   <= 1'b1;
                        end else begin
                            r_done <= 1'b0;
                        end
                        r_state <= r_is_start ? S_IDLE : S_EMIT;
                    end
                end

                S_RC_SQX: begin
                    r_state <= S_RC_A;
                end

                S_RC_A: begin
                    r_state <= S_RC_SQY;
                end

                // Hold ry^2 * (2x+1)^2 while (y-1)^2 is formed.
                S_RC_SQY: begin
                    r_dec   <= r_prod;
                    r_state <= S_RC_B;
                end

                S_RC_B: begin
                    r_state <= S_RC_FIN;
                end

                // Region two starts here; y is never negative at this point.
                S_RC_FIN: begin
                    r_dec   <= r_dec + DEC_W'({r_prod, 2'b00}) - DEC_W'({r_rxry, 2'b00});
                    r_reg2  <= 1'b1;
                    r_done  <= 1'b0;
                    r_state <= r_is_start ? S_IDLE : S_EMIT;
                end

                S_EMIT: begin
                    if (emit_load) begin
                        r_m_left  <= emit_left;
                        r_m_right <= emit_right;
                        r_m_row   <= emit_row;
                        r_m_empty <= r_empty;
                        r_m_last  <= (emit_rest == 4'b0000);
                        r_m_fin   <= r_done && !r_empty;
                        r_mask    <= emit_rest;
                        if (emit_rest == 4'b0000) begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output word packing.
    assign m_tvalid = r_m_valid;
    assign m_tdata  = M_DATA_W'({r_m_fin, r_m_row, r_m_right, r_m_left});
    assign m_tuser  = r_m_empty;
    assign m_tlast  = r_m_last;

`ifndef NO_ASSERTIONS
    // An empty word is always the whole step and never finishes an ellipse.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && !m_tdata[3*OUT_W])
        else $error("empty word without tlast or with finished set");

    // The emitter never runs with nothing left to send.
    a_emit_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_mask != 4'b0000))
        else $error("emit state with no pending result");

    // The region change is done once per ellipse.
    a_rc_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RC_FIN) |-> !r_reg2)
        else $error("region change while already in region two");

    // Empty results are made only with no ellipse active.
    a_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) && r_empty |-> !r_active)
        else $error("empty result while an ellipse is active");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mer_pkg::*;

    localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN = -(1 << (COORD_BITS - 1));

    // One result word as the rasterizer should produce it.
    typedef struct {
        logic signed [OUT_W-1:0] span_l;
        logic signed [OUT_W-1:0] span_r;
        logic signed [OUT_W-1:0] row;
        logic                    empty;
        logic                    last;
        logic                    fin;
    } t_pixel;

    // Tracks the ellipse being drawn and the result words still owed by the block.
    class ellipse_scoreboard;
        longint   cx, cy, rx, ry, wx, wy;
        longint   sdx, sdy, dcs;
        bit       region2, busy, fill;
        t_pixel   fresh[$];
        t_pixel   pending[$];
        int       errors;

        // Handles the switch to region two and the end of the ellipse.
        function bit settle_region();
            longint rx2, ry2;
            rx2 = rx * rx;
            ry2 = ry * ry;
            if (!region2 && !(sdx < sdy)) begin
                dcs = ry2 * (4 * wx * wx + 4 * wx + 1) + 4 * rx2 * (wy - 1) * (wy - 1)
                      - 4 * rx2 * ry2;
                region2 = 1'b1;
            end
            if (region2 && wy < 0) begin
                busy = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void plot(longint l, longint r, longint rw);
            t_pixel p;
            p.span_l = OUT_W'(l);
            p.span_r = OUT_W'(r);
            p.row    = OUT_W'(rw);
            p.empty  = 1'b0;
            p.last   = 1'b0;
            p.fin    = 1'b0;
            fresh.push_back(p);
        endfunction

        // Called for every accepted input word.
        function void note_word(logic cmd, longint ax, longint ay, longint bx, longint by,
                                logic solid);
            t_pixel p;
            longint x, y, d, e, rx2, ry2;
            bit     done;
            if (cmd == CMD_START) begin
                d = ax - bx;
                e = ay - by;
                rx = (d < 0 ? -d : d) / 2;
                ry = (e < 0 ? -e : e) / 2;
                cx = (ax + bx) / 2;
                cy = (ay + by) / 2;
                fill = solid;
                rx2 = rx * rx;
                ry2 = ry * ry;
                wx = 0;
                wy = ry;
                sdx = 0;
                sdy = 2 * rx2 * ry;
                dcs = 4 * ry2 - 4 * rx2 * ry + rx2;
                region2 = 1'b0;
                busy = 1'b1;
                void'(settle_region());
                return;
            end

            // A step with nothing to draw gives one empty word.
            if (!busy) begin
                p = '{default: '0};
                p.empty = 1'b1;
                p.last  = 1'b1;
                pending.push_back(p);
                return;
            end

            // Mirror the current first-quadrant point.
            fresh.delete();
            x = wx;
            y = wy;
            if (fill) begin
                plot(cx - x, cx + x, cy + y);
                if (y != 0)
                    plot(cx - x, cx + x, cy - y);
            end else begin
                plot(cx + x, cx + x, cy + y);
                if (x != 0)
                    plot(cx - x, cx - x, cy + y);
                if (y != 0) begin
                    plot(cx + x, cx + x, cy - y);
                    plot(cx - x, cx - x, cy - y);
                end
            end

            // Advance the walk; the decision term is four times the usual one.
            rx2 = rx * rx;
            ry2 = ry * ry;
            if (!region2) begin
                wx++;
                sdx += 2 * ry2;
                if (dcs < 0) begin
                    dcs += 4 * (sdx + ry2);
                end else begin
                    wy--;
                    sdy -= 2 * rx2;
                    dcs += 4 * (sdx - sdy + ry2);
                end
            end else begin
                wy--;
                sdy -= 2 * rx2;
                if (dcs > 0) begin
                    dcs += 4 * (rx2 - sdy);
                end else begin
                    wx++;
                    sdx += 2 * ry2;
                    dcs += 4 * (sdx - sdy + rx2);
                end
            end
            done = settle_region();

            foreach (fresh[k]) begin
                p = fresh[k];
                p.last = (k == fresh.size() - 1);
                p.fin  = done;
                pending.push_back(p);
            end
        endfunction

        function void compare(string name, logic signed [63:0] want, logic signed [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Called for every accepted output word.
        function void check_word(logic [M_DATA_W-1:0] data, logic empty, logic last);
            t_pixel want, got;
            got.span_l = data[OUT_W-1:0];
            got.span_r = data[2*OUT_W-1:OUT_W];
            got.row    = data[3*OUT_W-1:2*OUT_W];
            got.fin    = data[3*OUT_W];
            got.empty  = empty;
            got.last   = last;
            if (pending.size() == 0) begin
                errors++;
                $display("%t: unexpected word: expected none, actual left %0d right %0d row %0d",
                         $time, got.span_l, got.span_r, got.row);
                return;
            end
            want = pending.pop_front();
            compare("span_left", want.span_l, got.span_l);
            compare("span_right", want.span_r, got.span_r);
            compare("row", want.row, got.row);
            compare("empty", want.empty, got.empty);
            compare("tlast", want.last, got.last);
            compare("finished", want.fin, got.fin);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    ellipse_scoreboard     sb;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    int                    words_sent = 0;

    midpoint_ellipse_rasterizer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Output side: random back-pressure, results checked at the rising edge.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser[0], m_tlast);
    end

    // Sends one input word; entered and left at a falling edge.
    task automatic send_word(int cmd, int ax, int ay, int bx, int by, int solid);
        logic signed [COORD_BITS-1:0] f_ax, f_ay, f_bx, f_by;
        f_ax = COORD_BITS'(ax);
        f_ay = COORD_BITS'(ay);
        f_bx = COORD_BITS'(bx);
        f_by = COORD_BITS'(by);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_DATA_W'({solid[0], f_by, f_bx, f_ay, f_ax});
        s_tuser  = cmd[0];
        do @(posedge i_clk); while (s_tready !== 1'b1);
        sb.note_word(cmd[0], f_ax, f_ay, f_bx, f_by, solid[0]);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Box fields of a step word are ignored, so they carry noise.
    task automatic send_step();
        send_word(CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic trace_to_end(int cap);
        int n;
        n = 0;
        while (sb.busy && n < cap) begin
            send_step();
            n++;
        end
    endtask

    // Second corner at a given distance from the first, kept inside the field range.
    function automatic int partner(int a, int span);
        int b;
        b = ($urandom_range(1) == 1) ? a + span : a - span;
        if (b > CMAX || b < CMIN)
            b = 2 * a - b;
        return b;
    endfunction

    initial begin
        int base, kind, cap, span, ax, ay, bx, by;
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: idle step, single point, full-range boxes, truncating halving
        // of negative sums, flat and thin boxes, start while an ellipse is active.
        send_step();
        send_word(CMD_START, 0, 0, 0, 0, 0);
        trace_to_end(10);
        send_word(CMD_START, CMIN, CMIN, CMAX, CMAX, 1);
        trace_to_end(2);
        send_word(CMD_START, CMAX, CMAX, CMIN, CMIN, 0);
        trace_to_end(2);
        send_word(CMD_START, -3, -5, 0, 2, 0);
        trace_to_end(20);
        send_word(CMD_START, 10, -7, 11, 0, 1);
        trace_to_end(20);
        send_word(CMD_START, -9, 4, -2, 4, 0);
        trace_to_end(20);
        send_step();

        // Random ellipses, mostly run to completion, across the idling phases.
        base = words_sent;
        while (words_sent - base < 200) begin
            case ((words_sent - base) / 50)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 76; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 76; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            kind = $urandom_range(99);
            ax = $urandom_range(CMAX - CMIN) + CMIN;
            ay = $urandom_range(CMAX - CMIN) + CMIN;
            if (kind < 15) begin
                // Large boxes are only walked for a while, then abandoned.
                bx = $urandom_range(CMAX - CMIN) + CMIN;
                by = $urandom_range(CMAX - CMIN) + CMIN;
                cap = $urandom_range(3, 30);
            end else begin
                span = (kind < 70) ? 16 : 80;
                bx = partner(ax, $urandom_range(span));
                by = partner(ay, $urandom_range(span));
                cap = ($urandom_range(9) == 0) ? $urandom_range(1, 8) : 100000;
            end
            send_word(CMD_START, ax, ay, bx, by, $urandom_range(1));
            trace_to_end(cap);
            if (!sb.busy && $urandom_range(99) < 12)
                send_step();
        end
        s_tvalid = 1'b0;

        // Drain the outstanding words, then watch for stray ones.
        while (sb.pending.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mer_pkg.sv
rtl/midpoint_ellipse_rasterizer.sv
dv/tb.sv
